>>> design/fbh_pkg.sv
// ----------------------------------------------------------------------------
// fbh_pkg
// Shared types and constants for the first-fit byte heap allocator.
// ----------------------------------------------------------------------------
package fbh_pkg;

   // header position width: covers the pool plus one oversized hop past its end
   localparam int POS_W  = 10;
   localparam int BYTE_W = 8;
   localparam int FUNC_W = 2;

   // operation codes carried on req_tuser
   localparam logic [FUNC_W-1:0] FUNC_ALLOC    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COALESCE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd3;

   // header byte values and limits
   localparam logic [BYTE_W-1:0] FLAG_USED   = 8'd1;
   localparam logic [BYTE_W-1:0] FLAG_FREE   = 8'd0;
   localparam logic [POS_W-1:0]  MAX_SIZE    = 10'd255;
   localparam logic [POS_W-1:0]  MAX_PAYLOAD = 10'd255;
   localparam logic [POS_W-1:0]  HDR_BYTES   = 10'd2;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_SP1,
      ST_A_SP2,
      ST_A_SP3,
      ST_F_START,
      ST_F_SIZE,
      ST_AB_RD,
      ST_AB_CHK,
      ST_F_FIN,
      ST_C_RD,
      ST_C_CHK,
      ST_C_WR,
      ST_CLEAR,
      ST_DONE
   } ctrl_state_type;

   // datapath micro-operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_HDR_RD,
      OP_A_CHK,
      OP_A_SPLIT1,
      OP_A_SPLIT2,
      OP_A_SPLIT3,
      OP_FAIL,
      OP_F_START,
      OP_F_SIZE,
      OP_ABS_RD,
      OP_ABS_CHK,
      OP_F_FIN,
      OP_C_CHK,
      OP_C_WR,
      OP_CLEAR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_end;
      logic nx_end;
      logic hdr_free;
      logic fit;
      logic split;
      logic absorb_ok;
      logic off_bad;
   } dp_status_type;

endpackage

>>> design/first_fit_byte_heap.sv
// ----------------------------------------------------------------------------
// first_fit_byte_heap
// First-fit heap allocator over a byte pool with block headers, split on
// allocate, merge on free, a coalesce pass that reports the free total, and a clear.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                  | tuser
//  req_     | in        | request_size[7:0], block_offset[15:8] | func[1:0]
//  rsp_     | out       | payload_offset[7:0], free_total[15:8] | status[0]
//
// Per transaction: an accept step, the walk, a hand-off step. A visited header is read
// from the pool and then checked, a split makes three writes, a free clears the flag and
// reads the size, then reads and checks each merged block and writes the merged size, and
// a coalesce run ends each free span with a closing check and a write-back. Reset and
// clear restore the pool at once via per-byte valid bits. A stalled result holds in the
// output register while the next request is taken and walked.
// ----------------------------------------------------------------------------
module first_fit_byte_heap #(
   parameter int POOL_BYTES = 256,
   parameter int SIZE_GRAIN = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // request_size[7:0], block_offset[15:8]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // payload_offset[7:0], free_total[15:8]
   output logic        rsp_tuser    // status[0]
);

   fbh_pkg::dp_cmd_type             cmd;
   fbh_pkg::dp_status_type          status;
   logic [fbh_pkg::POS_W-1:0]       rd_a_pos, rd_b_pos, wr_pos;
   logic [fbh_pkg::BYTE_W-1:0]      rd_a_data, rd_b_data, wr_data;
   logic                            wr_en, pool_clear;
   logic [fbh_pkg::BYTE_W-1:0]      rsp_payload_offset, rsp_free_total;
   logic                            rsp_status;

   // controller
   fbh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   fbh_dpath #(
      .POOL_BYTES (POOL_BYTES),
      .SIZE_GRAIN (SIZE_GRAIN)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_request_size   (req_tdata[7:0]),
      .req_block_offset   (req_tdata[15:8]),
      .rd_a_pos           (rd_a_pos),
      .rd_b_pos           (rd_b_pos),
      .rd_a_data          (rd_a_data),
      .rd_b_data          (rd_b_data),
      .wr_en              (wr_en),
      .wr_pos             (wr_pos),
      .wr_data            (wr_data),
      .pool_clear         (pool_clear),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_free_total     (rsp_free_total)
   );

   // pool memory
   fbh_pool #(
      .POOL_BYTES (POOL_BYTES)
   ) u_pool (
      .clock     (clock),
      .reset     (reset),
      .clear     (pool_clear),
      .rd_a_pos  (rd_a_pos),
      .rd_b_pos  (rd_b_pos),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (wr_en),
      .wr_pos    (wr_pos),
      .wr_data   (wr_data)
   );

   assign rsp_tdata = {rsp_free_total, rsp_payload_offset};
   assign rsp_tuser = rsp_status;

endmodule

>>> design/fbh_pool.sv
// ----------------------------------------------------------------------------
// fbh_pool
// Pool byte memory: two registered read ports, one write port, per-byte
// valid bits so that reset and clear restore the initial pool at once.
// ----------------------------------------------------------------------------
module fbh_pool #(
   parameter int POOL_BYTES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic [fbh_pkg::POS_W-1:0]     rd_a_pos,
   input  logic [fbh_pkg::POS_W-1:0]     rd_b_pos,
   output logic [fbh_pkg::BYTE_W-1:0]    rd_a_data,
   output logic [fbh_pkg::BYTE_W-1:0]    rd_b_data,
   input  logic                          wr_en,
   input  logic [fbh_pkg::POS_W-1:0]     wr_pos,
   input  logic [fbh_pkg::BYTE_W-1:0]    wr_data
);

   localparam int ADDR_W = $clog2(POOL_BYTES);
   localparam logic [fbh_pkg::POS_W-1:0]  POOL_END   = fbh_pkg::POS_W'(POOL_BYTES);
   localparam logic [fbh_pkg::BYTE_W-1:0] RESET_SIZE = fbh_pkg::BYTE_W'(POOL_BYTES - 2);
   localparam logic [ADDR_W-1:0]          SIZE_ADDR  = ADDR_W'(1);

   logic [fbh_pkg::BYTE_W-1:0] pool_mem [POOL_BYTES];
   logic [POOL_BYTES-1:0]      valid_ff;

   logic                       a_range, b_range, w_range;
   logic [ADDR_W-1:0]          a_addr, b_addr, w_addr;

   logic [fbh_pkg::BYTE_W-1:0] a_mem_ff, b_mem_ff;
   logic                       a_valid_ff, b_valid_ff;
   logic                       a_range_ff, b_range_ff;
   logic                       a_size_ff, b_size_ff;

   // address decode, out-of-pool accesses clamped and masked
   assign a_range = rd_a_pos < POOL_END;
   assign b_range = rd_b_pos < POOL_END;
   assign w_range = wr_pos < POOL_END;
   assign a_addr  = a_range ? rd_a_pos[ADDR_W-1:0] : '0;
   assign b_addr  = b_range ? rd_b_pos[ADDR_W-1:0] : '0;
   assign w_addr  = w_range ? wr_pos[ADDR_W-1:0] : '0;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en && w_range) begin
         pool_mem[w_addr] <= wr_data;
      end
      a_mem_ff <= pool_mem[a_addr];
      b_mem_ff <= pool_mem[b_addr];
   end

   // valid bits: an unwritten byte reads as its initial value
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en && w_range) begin
         valid_ff[w_addr] <= 1'b1;
      end
   end

   // read side tags
   always_ff @(posedge clock) begin
      a_valid_ff <= valid_ff[a_addr];
      b_valid_ff <= valid_ff[b_addr];
      a_range_ff <= a_range;
      b_range_ff <= b_range;
      a_size_ff  <= a_addr == SIZE_ADDR;
      b_size_ff  <= b_addr == SIZE_ADDR;
   end

   // read data select
   always_comb begin
      if (!a_range_ff) begin
         rd_a_data = '0;
      end else if (a_valid_ff) begin
         rd_a_data = a_mem_ff;
      end else begin
         rd_a_data = a_size_ff ? RESET_SIZE : '0;
      end
      if (!b_range_ff) begin
         rd_b_data = '0;
      end else if (b_valid_ff) begin
         rd_b_data = b_mem_ff;
      end else begin
         rd_b_data = b_size_ff ? RESET_SIZE : '0;
      end
   end

endmodule

>>> design/fbh_dpath.sv
// ----------------------------------------------------------------------------
// fbh_dpath
// Heap datapath: walk pointers, size arithmetic, pool address generation
// and the result register.
// ----------------------------------------------------------------------------
module fbh_dpath #(
   parameter int POOL_BYTES = 256,
   parameter int SIZE_GRAIN = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fbh_pkg::dp_cmd_type           cmd,
   output fbh_pkg::dp_status_type        status,
   input  logic [fbh_pkg::BYTE_W-1:0]    req_request_size,
   input  logic [fbh_pkg::BYTE_W-1:0]    req_block_offset,
   output logic [fbh_pkg::POS_W-1:0]     rd_a_pos,
   output logic [fbh_pkg::POS_W-1:0]     rd_b_pos,
   input  logic [fbh_pkg::BYTE_W-1:0]    rd_a_data,
   input  logic [fbh_pkg::BYTE_W-1:0]    rd_b_data,
   output logic                          wr_en,
   output logic [fbh_pkg::POS_W-1:0]     wr_pos,
   output logic [fbh_pkg::BYTE_W-1:0]    wr_data,
   output logic                          pool_clear,
   output logic                          rsp_status,
   output logic [fbh_pkg::BYTE_W-1:0]    rsp_payload_offset,
   output logic [fbh_pkg::BYTE_W-1:0]    rsp_free_total
);

   localparam int PW = fbh_pkg::POS_W;
   localparam int BW = fbh_pkg::BYTE_W;
   localparam logic [PW-1:0] POOL_END = PW'(POOL_BYTES);
   localparam logic [PW-1:0] ONE      = PW'(1);
   localparam logic [PW-1:0] THREE    = PW'(3);

   // rounding table: request size to grain multiple
   logic [BW:0] round_tab [2**BW];
   for (genvar v = 0; v < 2**BW; v++) begin : g_round
      assign round_tab[v] = (BW+1)'(((v + SIZE_GRAIN - 1) / SIZE_GRAIN) * SIZE_GRAIN);
   end

   logic [BW:0]   need_ff, need_in;
   logic [BW-1:0] off_ff, off_in;
   logic [PW-1:0] idx_ff, idx_in;
   logic [PW-1:0] nx_ff, nx_in;
   logic [BW-1:0] ns_ff, ns_in;
   logic [BW-1:0] cur_ff, cur_in;
   logic          stat_ff, stat_in;
   logic [BW-1:0] payload_ff, payload_in;
   logic [BW-1:0] total_ff, total_in;

   logic [PW-1:0] cur_w, need_w, off_w, ns_w;
   logic [PW-1:0] hop, add, ns_sum;
   logic [BW:0]   total_sum;
   logic [BW-1:0] spare;

   assign cur_w  = PW'(rd_b_data);
   assign need_w = PW'(need_ff);
   assign off_w  = PW'(off_ff);
   assign ns_w   = PW'(ns_ff);
   assign hop    = cur_w + fbh_pkg::HDR_BYTES;
   assign add    = hop;
   assign ns_sum = ns_w + add;
   assign spare  = rd_b_data - need_ff[BW-1:0];
   assign total_sum = {1'b0, total_ff} + {1'b0, ns_ff};

   // status toward the controller
   always_comb begin
      status.idx_end   = (idx_ff + ONE) >= POOL_END;
      status.nx_end    = (nx_ff + ONE) >= POOL_END;
      status.hdr_free  = rd_a_data == fbh_pkg::FLAG_FREE;
      status.fit       = (rd_a_data == fbh_pkg::FLAG_FREE) && (need_w <= cur_w) &&
                         ((idx_ff + fbh_pkg::HDR_BYTES) <= fbh_pkg::MAX_PAYLOAD);
      status.split     = spare >= BW'(2);
      status.absorb_ok = (rd_a_data == fbh_pkg::FLAG_FREE) && (ns_sum <= fbh_pkg::MAX_SIZE);
      status.off_bad   = (off_ff < BW'(2)) || (off_w >= (POOL_END + ONE));
   end

   // pool addresses and writes
   always_comb begin
      rd_a_pos   = idx_ff;
      rd_b_pos   = idx_ff + ONE;
      wr_en      = 1'b0;
      wr_pos     = idx_ff;
      wr_data    = fbh_pkg::FLAG_FREE;
      pool_clear = 1'b0;
      case (cmd.op)
         fbh_pkg::OP_ABS_RD: begin
            rd_a_pos = nx_ff;
            rd_b_pos = nx_ff + ONE;
         end
         fbh_pkg::OP_A_CHK: begin
            wr_en   = status.fit;
            wr_data = fbh_pkg::FLAG_USED;
         end
         fbh_pkg::OP_A_SPLIT1: begin
            wr_en   = 1'b1;
            wr_pos  = idx_ff + ONE;
            wr_data = need_ff[BW-1:0];
         end
         fbh_pkg::OP_A_SPLIT2: begin
            wr_en   = 1'b1;
            wr_pos  = idx_ff + need_w + fbh_pkg::HDR_BYTES;
         end
         fbh_pkg::OP_A_SPLIT3: begin
            wr_en   = 1'b1;
            wr_pos  = idx_ff + need_w + THREE;
            wr_data = cur_ff - need_ff[BW-1:0] - BW'(2);
         end
         fbh_pkg::OP_F_START: begin
            rd_b_pos = off_w - ONE;
            wr_en    = 1'b1;
            wr_pos   = off_w - fbh_pkg::HDR_BYTES;
         end
         fbh_pkg::OP_F_FIN: begin
            wr_en   = 1'b1;
            wr_pos  = off_w - ONE;
            wr_data = ns_ff;
         end
         fbh_pkg::OP_C_WR: begin
            wr_en   = 1'b1;
            wr_pos  = idx_ff + ONE;
            wr_data = ns_ff;
         end
         fbh_pkg::OP_CLEAR: begin
            pool_clear = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // walk registers next value
   always_comb begin
      need_in    = need_ff;
      off_in     = off_ff;
      idx_in     = idx_ff;
      nx_in      = nx_ff;
      ns_in      = ns_ff;
      cur_in     = cur_ff;
      stat_in    = stat_ff;
      payload_in = payload_ff;
      total_in   = total_ff;
      case (cmd.op)
         fbh_pkg::OP_START: begin
            need_in    = round_tab[req_request_size];
            off_in     = req_block_offset;
            idx_in     = '0;
            stat_in    = 1'b0;
            payload_in = '0;
            total_in   = '0;
         end
         fbh_pkg::OP_A_CHK: begin
            if (status.fit) begin
               cur_in     = rd_b_data;
               payload_in = BW'(idx_ff + fbh_pkg::HDR_BYTES);
            end else begin
               idx_in = idx_ff + hop;
            end
         end
         fbh_pkg::OP_FAIL: begin
            stat_in = 1'b1;
         end
         fbh_pkg::OP_F_SIZE: begin
            ns_in = rd_b_data;
            nx_in = off_w + cur_w;
         end
         fbh_pkg::OP_ABS_CHK: begin
            if (status.absorb_ok) begin
               ns_in = BW'(ns_sum);
               nx_in = nx_ff + add;
            end
         end
         fbh_pkg::OP_C_CHK: begin
            if (status.hdr_free) begin
               ns_in = rd_b_data;
               nx_in = idx_ff + hop;
            end else begin
               idx_in = idx_ff + hop;
            end
         end
         fbh_pkg::OP_C_WR: begin
            // running free total saturates at the byte maximum
            total_in = total_sum[BW] ? {BW{1'b1}} : total_sum[BW-1:0];
            idx_in   = nx_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      need_ff    <= need_in;
      off_ff     <= off_in;
      idx_ff     <= idx_in;
      nx_ff      <= nx_in;
      ns_ff      <= ns_in;
      cur_ff     <= cur_in;
      stat_ff    <= stat_in;
      payload_ff <= payload_in;
      total_ff   <= total_in;
   end

   // result register, held while the transaction waits on the output
   logic          rsp_status_ff;
   logic [BW-1:0] rsp_payload_ff, rsp_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_status_ff  <= 1'b0;
         rsp_payload_ff <= '0;
         rsp_total_ff   <= '0;
      end else if (cmd.rsp_load) begin
         rsp_status_ff  <= stat_ff;
         rsp_payload_ff <= payload_ff;
         rsp_total_ff   <= total_ff;
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_payload_ff;
   assign rsp_free_total     = rsp_total_ff;

endmodule

>>> design/fbh_ctrl.sv
// ----------------------------------------------------------------------------
// fbh_ctrl
// Heap controller: sequences header walks, splits and merges, and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module fbh_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fbh_pkg::FUNC_W-1:0]    req_func,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  fbh_pkg::dp_status_type        status,
   output fbh_pkg::dp_cmd_type           cmd
);

   fbh_pkg::ctrl_state_type         state_ff, state_in;
   logic [fbh_pkg::FUNC_W-1:0]      func_ff, func_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   fbh_pkg::ctrl_state_type         absorb_exit;

   // state and handshake registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbh_pkg::ST_IDLE;
         func_ff      <= fbh_pkg::FUNC_ALLOC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         func_ff      <= func_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // merge walk returns to free finish or to the coalesce write-back
   assign absorb_exit = (func_ff == fbh_pkg::FUNC_FREE) ? fbh_pkg::ST_F_FIN
                                                         : fbh_pkg::ST_C_WR;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      cmd.op       = fbh_pkg::OP_NONE;
      cmd.rsp_load = 1'b0;
      req_tready   = 1'b0;
      case (state_ff)
         fbh_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op  = fbh_pkg::OP_START;
               func_in = req_func;
               case (req_func)
                  fbh_pkg::FUNC_ALLOC:    state_in = fbh_pkg::ST_A_RD;
                  fbh_pkg::FUNC_FREE:     state_in = fbh_pkg::ST_F_START;
                  fbh_pkg::FUNC_COALESCE: state_in = fbh_pkg::ST_C_RD;
                  fbh_pkg::FUNC_CLEAR:    state_in = fbh_pkg::ST_CLEAR;
                  default:                state_in = fbh_pkg::ST_IDLE;
               endcase
            end
         end
         fbh_pkg::ST_A_RD: begin
            if (status.idx_end) begin
               cmd.op   = fbh_pkg::OP_FAIL;
               state_in = fbh_pkg::ST_DONE;
            end else begin
               cmd.op   = fbh_pkg::OP_HDR_RD;
               state_in = fbh_pkg::ST_A_CHK;
            end
         end
         fbh_pkg::ST_A_CHK: begin
            cmd.op = fbh_pkg::OP_A_CHK;
            if (!status.fit) begin
               state_in = fbh_pkg::ST_A_RD;
            end else if (status.split) begin
               state_in = fbh_pkg::ST_A_SP1;
            end else begin
               state_in = fbh_pkg::ST_DONE;
            end
         end
         fbh_pkg::ST_A_SP1: begin
            cmd.op   = fbh_pkg::OP_A_SPLIT1;
            state_in = fbh_pkg::ST_A_SP2;
         end
         fbh_pkg::ST_A_SP2: begin
            cmd.op   = fbh_pkg::OP_A_SPLIT2;
            state_in = fbh_pkg::ST_A_SP3;
         end
         fbh_pkg::ST_A_SP3: begin
            cmd.op   = fbh_pkg::OP_A_SPLIT3;
            state_in = fbh_pkg::ST_DONE;
         end
         fbh_pkg::ST_F_START: begin
            if (status.off_bad) begin
               state_in = fbh_pkg::ST_DONE;
            end else begin
               cmd.op   = fbh_pkg::OP_F_START;
               state_in = fbh_pkg::ST_F_SIZE;
            end
         end
         fbh_pkg::ST_F_SIZE: begin
            cmd.op   = fbh_pkg::OP_F_SIZE;
            state_in = fbh_pkg::ST_AB_RD;
         end
         fbh_pkg::ST_AB_RD: begin
            if (status.nx_end) begin
               state_in = absorb_exit;
            end else begin
               cmd.op   = fbh_pkg::OP_ABS_RD;
               state_in = fbh_pkg::ST_AB_CHK;
            end
         end
         fbh_pkg::ST_AB_CHK: begin
            cmd.op   = fbh_pkg::OP_ABS_CHK;
            state_in = status.absorb_ok ? fbh_pkg::ST_AB_RD : absorb_exit;
         end
         fbh_pkg::ST_F_FIN: begin
            cmd.op   = fbh_pkg::OP_F_FIN;
            state_in = fbh_pkg::ST_DONE;
         end
         fbh_pkg::ST_C_RD: begin
            if (status.idx_end) begin
               state_in = fbh_pkg::ST_DONE;
            end else begin
               cmd.op   = fbh_pkg::OP_HDR_RD;
               state_in = fbh_pkg::ST_C_CHK;
            end
         end
         fbh_pkg::ST_C_CHK: begin
            cmd.op   = fbh_pkg::OP_C_CHK;
            state_in = status.hdr_free ? fbh_pkg::ST_AB_RD : fbh_pkg::ST_C_RD;
         end
         fbh_pkg::ST_C_WR: begin
            cmd.op   = fbh_pkg::OP_C_WR;
            state_in = fbh_pkg::ST_C_RD;
         end
         fbh_pkg::ST_CLEAR: begin
            cmd.op   = fbh_pkg::OP_CLEAR;
            state_in = fbh_pkg::ST_DONE;
         end
         fbh_pkg::ST_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = fbh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbh_pkg::ST_IDLE;
         end
      endcase
   end

   // output valid
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

endmodule
